// ===== src/gfa_pkg.sv =====
// ----------------------------------------------------------------------------
// gfa_pkg: shared definitions for the GF(2^8) arithmetic unit
// Holds the operation codes, the field constants, the stage control types and
// the fixed logarithm and exponent tables of the generator x over 0x11D.
// ----------------------------------------------------------------------------
package gfa_pkg;

  localparam logic [1:0] KIND_MUL = 2'd0;
  localparam logic [1:0] KIND_DIV = 2'd1;
  localparam logic [1:0] KIND_EXP = 2'd2;
  localparam logic [1:0] KIND_LOG = 2'd3;

  localparam logic [8:0] FIELD_POLY  = 9'h11D;
  localparam logic [8:0] GROUP_ORDER = 9'd255;

  typedef logic [7:0] tab_t [256];

  // Control carried from the lookup stage into the result register.
  typedef struct packed {
    logic       use_log;
    logic       force_zero;
    logic       div_by_zero;
    logic [7:0] log_val;
  } out_ctrl_t;

  function automatic tab_t build_exp();
    tab_t       t;
    logic [7:0] f;
    int         p;
    f = 8'd1;
    for (p = 0; p < 255; p++) begin
      t[p] = f;
      f = {f[6:0], 1'b0} ^ (f[7] ? FIELD_POLY[7:0] : 8'h00);
    end
    t[255] = 8'd1;
    return t;
  endfunction

  function automatic tab_t build_log();
    tab_t       t;
    logic [7:0] f;
    int         p;
    t[0] = 8'd0;
    f = 8'd1;
    for (p = 0; p < 255; p++) begin
      t[f] = p[7:0];
      f = {f[6:0], 1'b0} ^ (f[7] ? FIELD_POLY[7:0] : 8'h00);
    end
    return t;
  endfunction

  localparam tab_t EXP_TAB = build_exp();
  localparam tab_t LOG_TAB = build_log();

endpackage

// ===== src/gfa_log_rom.sv =====
// ----------------------------------------------------------------------------
// gfa_log_rom: discrete logarithm table with two registered read ports
// Both operands are looked up in the same cycle; the read data is registered.
// ----------------------------------------------------------------------------
module gfa_log_rom (
  input  logic       clk,
  input  logic       en,
  input  logic [7:0] addr_a,
  input  logic [7:0] addr_b,
  output logic [7:0] data_a,
  output logic [7:0] data_b
);
  import gfa_pkg::*;

  always_ff @(posedge clk) begin
    if (en) begin
      data_a <= LOG_TAB[addr_a];
      data_b <= LOG_TAB[addr_b];
    end
  end

endmodule

// ===== src/gfa_exp_rom.sv =====
// ----------------------------------------------------------------------------
// gfa_exp_rom: exponent table of the generator with one registered read port
// Read data holds while the enable is low.
// ----------------------------------------------------------------------------
module gfa_exp_rom (
  input  logic       clk,
  input  logic       en,
  input  logic [7:0] addr,
  output logic [7:0] data
);
  import gfa_pkg::*;

  always_ff @(posedge clk) begin
    if (en) begin
      data <= EXP_TAB[addr];
    end
  end

endmodule

// ===== src/gfa_index.sv =====
// ----------------------------------------------------------------------------
// gfa_index: exponent index calculation modulo 255
// One shared adder and a single conditional subtract serve multiply, divide
// and the folded power of the exponent operation.
// ----------------------------------------------------------------------------
module gfa_index (
  input  logic [1:0] kind,
  input  logic [7:0] log_a,
  input  logic [7:0] log_b,
  input  logic [9:0] power_sum,
  output logic [7:0] idx
);
  import gfa_pkg::*;

  logic [8:0] x;
  logic [8:0] y;
  logic [8:0] sum;
  logic [8:0] red;

  always_comb begin
    unique case (kind)
      KIND_MUL: begin
        x = {1'b0, log_a};
        y = {1'b0, log_b};
      end
      KIND_DIV: begin
        // Logarithms never exceed 254, so the complement stays positive.
        x = {1'b0, log_a};
        y = GROUP_ORDER - {1'b0, log_b};
      end
      KIND_EXP: begin
        x = {1'b0, power_sum[7:0]};
        y = {7'd0, power_sum[9:8]};
      end
      default: begin
        x = 9'd0;
        y = 9'd0;
      end
    endcase
  end

  // The sum never reaches 510, so one subtract brings it into range.
  assign sum = x + y;
  assign red = (sum >= GROUP_ORDER) ? (sum - GROUP_ORDER) : sum;
  assign idx = red[7:0];

endmodule

// ===== src/gf256_arithmetic_unit.sv =====
// ----------------------------------------------------------------------------
// gf256_arithmetic_unit: GF(2^8) multiply, divide, exponent and logarithm
// Each input beat carries an operation code and its operands; each produces
// exactly one output beat with the result and a divide-by-zero flag.
//
// Usage: the input channel is in_valid/in_stall with the fields kind,
// operand_a, operand_b and power; the output channel is out_valid/out_stall
// with result and div_by_zero. A beat moves when valid is high and stall is
// low. The unit has two stages: the first reads the logarithm table for both
// operands and folds the 32-bit power into a ten-bit byte sum; the second
// reduces the index modulo 255 and reads the exponent table into the output
// register. An accepted beat moves from the first stage into the output
// register when that register is free, and the unit takes one beat every
// cycle while the receiver keeps up.
// When the receiver stalls, the output beat holds and the first stage still
// accepts one more beat, so a stall reaches in_stall after that beat unless
// the pipeline is already full. A synchronous reset empties both stages;
// the tables are constants and need no filling after reset.
// ----------------------------------------------------------------------------
module gf256_arithmetic_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  kind,
  input  logic [7:0]  operand_a,
  input  logic [7:0]  operand_b,
  input  logic [31:0] power,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  result,
  output logic        div_by_zero
);
  import gfa_pkg::*;

  // Stage one registers.
  logic       v1;
  logic [1:0] kind1;
  logic       a_zero1;
  logic       b_zero1;
  logic [9:0] power_sum1;
  logic [7:0] log_a1;
  logic [7:0] log_b1;

  // Stage two (output) registers.
  logic       v2;
  out_ctrl_t  ctrl2;
  out_ctrl_t  ctrl_next;
  logic [7:0] exp_data2;

  logic       ready1;
  logic       ready2;
  logic [9:0] power_sum;
  logic [7:0] exp_idx;

  // Each stage advances when it is empty or its content moves on.
  assign ready2   = !v2 || !out_stall;
  assign ready1   = !v1 || ready2;
  assign in_stall = !ready1;

  // Since 256 is congruent to 1 modulo 255, the byte sum of the power keeps
  // its residue.
  assign power_sum = {2'b00, power[7:0]} + {2'b00, power[15:8]}
                   + {2'b00, power[23:16]} + {2'b00, power[31:24]};

  gfa_log_rom u_log_rom (
    .clk    (clk),
    .en     (ready1),
    .addr_a (operand_a),
    .addr_b (operand_b),
    .data_a (log_a1),
    .data_b (log_b1)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (ready1) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready1) begin
      kind1      <= kind;
      a_zero1    <= (operand_a == 8'd0);
      b_zero1    <= (operand_b == 8'd0);
      power_sum1 <= power_sum;
    end
  end

  gfa_index u_index (
    .kind      (kind1),
    .log_a     (log_a1),
    .log_b     (log_b1),
    .power_sum (power_sum1),
    .idx       (exp_idx)
  );

  // Zero operands of a multiply or divide bypass the tables; only a divide of
  // a nonzero value by zero raises the flag.
  always_comb begin
    ctrl_next.use_log     = (kind1 == KIND_LOG);
    ctrl_next.log_val     = log_a1;
    ctrl_next.force_zero  = 1'b0;
    ctrl_next.div_by_zero = 1'b0;
    case (kind1)
      KIND_MUL: ctrl_next.force_zero = a_zero1 || b_zero1;
      KIND_DIV: begin
        ctrl_next.force_zero  = a_zero1 || b_zero1;
        ctrl_next.div_by_zero = !a_zero1 && b_zero1;
      end
      default: ctrl_next.force_zero = 1'b0;
    endcase
  end

  gfa_exp_rom u_exp_rom (
    .clk  (clk),
    .en   (ready2),
    .addr (exp_idx),
    .data (exp_data2)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (ready2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (ready2) begin
      ctrl2 <= ctrl_next;
    end
  end

  assign out_valid   = v2;
  assign div_by_zero = ctrl2.div_by_zero;
  assign result      = ctrl2.use_log    ? ctrl2.log_val :
                       ctrl2.force_zero ? 8'd0 : exp_data2;

`ifndef ASSERT_OFF
  // A flagged divide always carries a zero result.
  a_dbz_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && div_by_zero |-> result == 8'd0)
    else $error("divide by zero with nonzero result");

  // With both stages full and the receiver stalled, no beat may enter.
  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    v1 && v2 && out_stall |-> in_stall)
    else $error("input accepted into a full pipeline");

  // An accepted beat occupies the first stage in the next cycle.
  a_accept_v1: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> v1)
    else $error("accepted beat lost from first stage");
`endif

endmodule
